// File: src/row_pair_bit_interleaver_defines.svh
// ----------------------------------------------------------------------------
// row_pair_bit_interleaver_defines.svh
// assertion macros used by the rpbi_checker file
// ----------------------------------------------------------------------------
`ifndef ROW_PAIR_BIT_INTERLEAVER_DEFINES_SVH
`define ROW_PAIR_BIT_INTERLEAVER_DEFINES_SVH

// same-cycle implication
`define RPBI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rpbi assertion failed");

// next-cycle implication
`define RPBI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rpbi assertion failed");

`endif

// File: src/rpbi_pkg.sv
// ----------------------------------------------------------------------------
// rpbi_pkg
// shared widths, types and the bit merge function of the row pair interleaver
// ----------------------------------------------------------------------------
`default_nettype none

package rpbi_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CFG_W  = 7;
	localparam int unsigned CNT_W  = 9;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} ls_ctl_t;

	// t/b nibble into one byte: t0 b0 t1 b1 t2 b2 t3 b3 from bit 7 down
	function automatic logic [BYTE_W-1:0] merge_nib(input logic [3:0] t, input logic [3:0] b);
		logic [BYTE_W-1:0] r;
		r = '0;
		for (int k = 0; k < 4; k++) begin
			r[7-2*k] = t[k];
			r[6-2*k] = b[k];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: src/row_pair_bit_interleaver.sv
// ----------------------------------------------------------------------------
// row_pair_bit_interleaver
// repacks 1 bpp raster bytes into vertically paired pixel bytes
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata pixel_byte, tuser start_of_window
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata out_byte, tlast last_of_pair
// cfg       in   cfg_wr_en                      cfg_wr_data row_bytes
//
// even-row words are written to the line store
// odd-row words read the line store and leave two output words, one per cycle
// while m_axis_tready is high, so an odd-row word waits until the pair ahead has gone
// one input stage register and one result register decouple the two sides
// reset clears counters, row parity and valid flags; line store is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module row_pair_bit_interleaver
	import rpbi_pkg::*;
#(
	parameter int unsigned MAX_ROW_BYTES = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [CFG_W-1:0]  cfg_wr_data,    // [6:0] row_bytes
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] pixel_byte
	input  wire logic              s_axis_tuser,   // [0] start_of_window
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic      [BYTE_W-1:0] m_axis_tdata,   // [7:0] out_byte
	output logic                   m_axis_tlast
);

	localparam int unsigned AW = $clog2(MAX_ROW_BYTES);

	ls_ctl_t           ctl;
	logic [AW-1:0]     addr;
	logic [BYTE_W-1:0] top;
	logic              accept;
	logic              take;
	logic              adv;
	logic              load;

	logic              valid_s1;
	logic              odd_s1;
	logic [BYTE_W-1:0] bot_s1;

	assign adv           = valid_s1 & (~odd_s1 | take);
	assign s_axis_tready = ~valid_s1 | adv;
	assign accept        = s_axis_tvalid & s_axis_tready;
	assign load          = valid_s1 & odd_s1;

	rpbi_ctrl #(
		.MAX_ROW_BYTES(MAX_ROW_BYTES),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.accept(accept),
		.start(s_axis_tuser),
		.ctl(ctl),
		.addr(addr)
	);

	rpbi_line_store #(
		.DEPTH(MAX_ROW_BYTES),
		.AW(AW)
	) u_store (
		.clk(clk),
		.ctl(ctl),
		.addr(addr),
		.wr_data(s_axis_tdata),
		.rd_data_q(top)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			bot_s1 <= s_axis_tdata;
			odd_s1 <= ctl.rd_en;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	rpbi_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.top(top),
		.bot(bot_s1),
		.take(take),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

endmodule

`default_nettype wire

// File: src/rpbi_line_store.sv
// ----------------------------------------------------------------------------
// rpbi_line_store
// single-port line memory holding the top row of a pair, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module rpbi_line_store
	import rpbi_pkg::*;
#(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  wire logic              clk,
	input  wire ls_ctl_t           ctl,
	input  wire logic [AW-1:0]     addr,
	input  wire logic [BYTE_W-1:0] wr_data,
	output logic      [BYTE_W-1:0] rd_data_q
);

	logic [BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// File: src/rpbi_ctrl.sv
// ----------------------------------------------------------------------------
// rpbi_ctrl
// row length register, column counter and row parity, line store access
// ----------------------------------------------------------------------------
`default_nettype none

module rpbi_ctrl
	import rpbi_pkg::*;
#(
	parameter int unsigned MAX_ROW_BYTES = 64,
	parameter int unsigned AW            = 6
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CFG_W-1:0] cfg_wr_data,
	input  wire logic             accept,
	input  wire logic             start,
	output ls_ctl_t               ctl,
	output logic      [AW-1:0]    addr
);

	localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_ROW_BYTES);

	logic [CFG_W-1:0] row_bytes_q;
	logic [AW-1:0]    col_q;
	logic             odd_q;

	logic [CNT_W-1:0] len;
	logic [CNT_W-1:0] rb_ext;
	logic [AW-1:0]    col0;
	logic             odd0;
	logic [AW-1:0]    col1;
	logic             odd1;
	logic [CNT_W-1:0] col_nxt;
	logic [AW-1:0]    col_d;
	logic             odd_d;

	always_comb begin
		rb_ext = CNT_W'(row_bytes_q);
		if (rb_ext == '0) begin
			len = CNT_W'(1);
		end else if (rb_ext > MAX_LEN) begin
			len = MAX_LEN;
		end else begin
			len = rb_ext;
		end

		col0 = start ? '0 : col_q;
		odd0 = start ? 1'b0 : odd_q;

		// row ends early when the length shrank under the counter
		if (CNT_W'(col0) >= len) begin
			col1 = '0;
			odd1 = ~odd0;
		end else begin
			col1 = col0;
			odd1 = odd0;
		end

		col_nxt = CNT_W'(col1) + CNT_W'(1);
		if (col_nxt >= len) begin
			col_d = '0;
			odd_d = ~odd1;
		end else begin
			col_d = col_nxt[AW-1:0];
			odd_d = odd1;
		end

		addr      = col1;
		ctl.wr_en = accept & ~odd1;
		ctl.rd_en = accept & odd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= CFG_W'(1);
		end else if (cfg_wr_en) begin
			row_bytes_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			odd_q <= 1'b0;
		end else if (accept) begin
			col_q <= col_d;
			odd_q <= odd_d;
		end
	end

endmodule

`default_nettype wire

// File: src/rpbi_out.sv
// ----------------------------------------------------------------------------
// rpbi_out
// bit merge and result register, sends the two bytes of a pair in turn
// ----------------------------------------------------------------------------
`default_nettype none

module rpbi_out
	import rpbi_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire logic [BYTE_W-1:0] top,
	input  wire logic [BYTE_W-1:0] bot,
	output logic                   take,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic      [BYTE_W-1:0] m_axis_tdata,
	output logic                   m_axis_tlast
);

	logic [2*BYTE_W-1:0] pair_q;
	logic                phase_q;
	logic                valid_q;

	assign take          = ~valid_q | (phase_q & m_axis_tready);
	assign m_axis_tvalid = valid_q;
	assign m_axis_tlast  = phase_q;
	assign m_axis_tdata  = phase_q ? pair_q[2*BYTE_W-1:BYTE_W] : pair_q[BYTE_W-1:0];

	always_ff @(posedge clk) begin
		if (load && take) begin
			pair_q <= {merge_nib(top[7:4], bot[7:4]), merge_nib(top[3:0], bot[3:0])};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load && take) begin
			valid_q <= 1'b1;
			phase_q <= 1'b0;
		end else if (valid_q && m_axis_tready) begin
			if (phase_q) begin
				valid_q <= 1'b0;
				phase_q <= 1'b0;
			end else begin
				phase_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/rpbi_checker.sv
// ----------------------------------------------------------------------------
// rpbi_checker
// port-level checks of the row pair interleaver, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "row_pair_bit_interleaver_defines.svh"

module rpbi_checker
	import rpbi_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              cfg_wr_en,
	input wire logic [CFG_W-1:0]  cfg_wr_data,
	input wire logic              s_axis_tvalid,
	input wire logic              s_axis_tready,
	input wire logic [BYTE_W-1:0] s_axis_tdata,
	input wire logic              s_axis_tuser,
	input wire logic              m_axis_tvalid,
	input wire logic              m_axis_tready,
	input wire logic [BYTE_W-1:0] m_axis_tdata,
	input wire logic              m_axis_tlast
);

	// stalled output word holds
	`RPBI_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

	// second word of a pair is ready right after the first is taken
	`RPBI_ASSERT_NEXT(a_pair_second, clk, arst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && m_axis_tlast)

	// a fresh last word always follows a taken first word
	`RPBI_ASSERT_SAME(a_pair_first, clk, arst_n, m_axis_tvalid && m_axis_tlast && !$past(m_axis_tvalid && m_axis_tlast), $past(m_axis_tvalid && m_axis_tready && !m_axis_tlast))

endmodule

bind row_pair_bit_interleaver rpbi_checker u_rpbi_checker (.*);

`default_nettype wire

// File: tb/interleave_checker.sv
// ----------------------------------------------------------------------------
// interleave_checker
// watches the pixel, result and config channels of row_pair_bit_interleaver,
// keeps its own line store and row position, predicts the two paired words of
// every bottom-row word and compares them in order with the result channel
// ----------------------------------------------------------------------------
module interleave_checker
	import rpbi_pkg::*;
#(
	parameter int unsigned MAX_ROW_BYTES = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [CFG_W-1:0]  cfg_wr_data,
	input  wire logic              s_axis_tvalid,
	input  wire logic              s_axis_tready,
	input  wire logic [BYTE_W-1:0] s_axis_tdata,
	input  wire logic              s_axis_tuser,
	input  wire logic              m_axis_tvalid,
	input  wire logic              m_axis_tready,
	input  wire logic [BYTE_W-1:0] m_axis_tdata,
	input  wire logic              m_axis_tlast,
	output int                     fail_count,
	output int                     pending
);

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} paired_word_t;

	paired_word_t      paired_q[$];
	logic [BYTE_W-1:0] top_row [MAX_ROW_BYTES];
	logic [CFG_W-1:0]  row_bytes;
	int unsigned       col;
	logic              bottom;
	int                errors;

	function automatic int unsigned row_len(input logic [CFG_W-1:0] rb);
		if (rb == 0)
			return 1;
		if (rb > MAX_ROW_BYTES)
			return MAX_ROW_BYTES;
		return rb;
	endfunction

	// bit k of top and bottom land side by side, top bit 0 in bit 15
	function automatic logic [2*BYTE_W-1:0] interleave_rows(input logic [BYTE_W-1:0] t,
			input logic [BYTE_W-1:0] b);
		logic [2*BYTE_W-1:0] w;
		for (int k = 0; k < BYTE_W; k++) begin
			w[15-2*k] = t[k];
			w[14-2*k] = b[k];
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		paired_word_t        want;
		int unsigned         len;
		logic [2*BYTE_W-1:0] pair;
		if (!arst_n) begin
			paired_q.delete();
			row_bytes = 1;
			col = 0;
			bottom = 1'b0;
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (paired_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected word, expected none, actual tdata %02h tlast %0b",
						$time, m_axis_tdata, m_axis_tlast);
				end else begin
					want = paired_q.pop_front();
					if (m_axis_tdata !== want.data) begin
						errors++;
						$display("%0t: tdata mismatch, expected %02h, actual %02h",
							$time, want.data, m_axis_tdata);
					end
					if (m_axis_tlast !== want.last) begin
						errors++;
						$display("%0t: tlast mismatch, expected %0b, actual %0b",
							$time, want.last, m_axis_tlast);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				len = row_len(row_bytes);
				if (s_axis_tuser) begin
					col = 0;
					bottom = 1'b0;
				end
				// row ends early when the width shrank below the column
				if (col >= len) begin
					col = 0;
					bottom = ~bottom;
				end
				if (!bottom) begin
					top_row[col] = s_axis_tdata;
				end else begin
					pair = interleave_rows(top_row[col], s_axis_tdata);
					paired_q.push_back('{data: pair[15:8], last: 1'b0});
					paired_q.push_back('{data: pair[7:0], last: 1'b1});
				end
				col++;
				if (col >= len) begin
					col = 0;
					bottom = ~bottom;
				end
			end
			if (cfg_wr_en)
				row_bytes = cfg_wr_data;
			pending <= paired_q.size();
		end
		fail_count <= errors;
	end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus for row_pair_bit_interleaver: directed words for bit patterns,
// out-of-range widths, mid-row width shrink and dropped top rows, then random
// windows over many row widths with random gaps on both channels
// ----------------------------------------------------------------------------
module tb_top;
	import rpbi_pkg::*;

	localparam int unsigned MAX_ROW_BYTES = 64;
	localparam int          CYCLE_LIMIT   = 400000;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [CFG_W-1:0]  cfg_wr_data;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [BYTE_W-1:0] s_axis_tdata;
	logic              s_axis_tuser;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [BYTE_W-1:0] m_axis_tdata;
	logic              m_axis_tlast;

	int          fail_count;
	int          pending;
	int          stall_left = 0;
	int          cycle_cnt;
	bit          calm = 1'b0;
	bit          quiet = 1'b0;
	bit          need_sow = 1'b0;
	int unsigned row_len_now = 1;

	always #5 clk = ~clk;

	row_pair_bit_interleaver #(
		.MAX_ROW_BYTES(MAX_ROW_BYTES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	interleave_checker #(
		.MAX_ROW_BYTES(MAX_ROW_BYTES)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// result side back-pressure
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!calm && !quiet && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(1, 7) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		for (cycle_cnt = 0; cycle_cnt < CYCLE_LIMIT; cycle_cnt++)
			@(posedge clk);
		$display("simulation failed");
		$finish;
	end

	task automatic send_word(input logic [BYTE_W-1:0] pix, input logic sow);
		int gap;
		if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pix;
		s_axis_tuser <= sow | need_sow;
		need_sow = 1'b0;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// written only with both channels drained
	task automatic set_row_bytes(input logic [CFG_W-1:0] v);
		int unsigned len;
		len = (v == 0) ? 1 : ((v > MAX_ROW_BYTES) ? MAX_ROW_BYTES : v);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		// a wider row would reach line store entries not yet written
		if (len > row_len_now)
			need_sow = 1'b1;
		row_len_now = len;
	endtask

	initial begin
		int               rand_items;
		int               phase;
		int               windows;
		int               pairs;
		int               rows;
		int               cols;
		int               pick;
		bit               cut;
		bit               sow;
		logic [CFG_W-1:0] rb;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset width of one byte: plain bit patterns
		send_word(8'hFF, 1'b1);
		send_word(8'h00, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'hAA, 1'b0);
		send_word(8'h55, 1'b0);
		send_word(8'h0F, 1'b0);
		send_word(8'hF0, 1'b0);

		// zero width acts as one
		set_row_bytes(7'd0);
		send_word(8'h3C, 1'b1);
		send_word(8'hC3, 1'b0);

		// shrink in the middle of a bottom row ends it early
		set_row_bytes(7'd3);
		send_word(8'h12, 1'b1);
		send_word(8'h34, 1'b0);
		send_word(8'h56, 1'b0);
		send_word(8'h81, 1'b0);
		send_word(8'h7E, 1'b0);
		set_row_bytes(7'd2);
		send_word(8'h9A, 1'b0);
		send_word(8'hBC, 1'b0);
		send_word(8'hDE, 1'b0);
		send_word(8'h01, 1'b0);

		// top row without a bottom row is dropped by a new window
		send_word(8'hE7, 1'b1);
		send_word(8'h18, 1'b1);
		send_word(8'h66, 1'b0);
		send_word(8'h99, 1'b0);
		send_word(8'hC0, 1'b0);

		rand_items = 0;
		phase = 0;
		while (rand_items < 500) begin
			case (phase)
				0: rb = 7'd127;
				1: rb = 7'd64;
				2: rb = 7'd0;
				3: rb = 7'd1;
				default: begin
					pick = $urandom_range(0, 31);
					if (pick == 0)
						rb = CFG_W'($urandom_range(65, 127));
					else if (pick == 1)
						rb = CFG_W'($urandom_range(17, 64));
					else if (pick == 2)
						rb = 7'd0;
					else
						rb = CFG_W'($urandom_range(1, 16));
				end
			endcase
			phase++;
			calm = (rand_items > 430);
			quiet = ($urandom_range(0, 3) == 0);
			set_row_bytes(rb);
			windows = (row_len_now > 16) ? 1 : $urandom_range(1, 3);
			for (int w = 0; w < windows; w++) begin
				pairs = (row_len_now > 16) ? 1 : $urandom_range(1, 3);
				rows = 2 * pairs;
				cut = ($urandom_range(0, 4) == 0);
				for (int r = 0; r < rows + cut; r++) begin
					cols = (r == rows) ? $urandom_range(1, row_len_now) : row_len_now;
					for (int c = 0; c < cols; c++) begin
						sow = (r == 0 && c == 0 && (w > 0 || $urandom_range(0, 1) == 1))
							|| ($urandom_range(0, 59) == 0);
						send_word(BYTE_W'($urandom_range(0, 255)), sow);
						rand_items++;
					end
				end
			end
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// File: row_pair_bit_interleaver.f
+incdir+src
src/rpbi_pkg.sv
src/rpbi_line_store.sv
src/rpbi_ctrl.sv
src/rpbi_out.sv
src/row_pair_bit_interleaver.sv
src/rpbi_checker.sv
tb/interleave_checker.sv
tb/tb_top.sv
